### rtl/core/assert_macros.svh
// assertion helpers shared by the rtl
// the enclosing module must provide clk and arst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// expression must never be true at a clock edge out of reset
`define ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

### rtl/core/rgbhc_pkg.sv
// ----------------------------------------------------------------------------
// rgbhc_pkg
// Types and constants of the rgb lamp hue-cycle mode controller.
// ----------------------------------------------------------------------------
package rgbhc_pkg;

	typedef logic [10:0] duty_t;
	typedef logic [13:0] hue_t;
	typedef logic [12:0] rem_t;
	typedef logic [3:0]  mode_t;
	typedef logic [2:0]  tick_t;
	typedef logic [2:0]  op_t;

	typedef struct packed {
		op_t  opcode;
		logic power_value;
	} evt_t;

	typedef struct packed {
		duty_t red_duty;
		duty_t green_duty;
		duty_t blue_duty;
		logic  lamp_on;
		mode_t active_mode;
	} res_t;

	typedef struct packed {
		duty_t red;
		duty_t green;
		duty_t blue;
		hue_t  hue_nxt;
		duty_t frac_nxt;
		rem_t  rem_nxt;
		tick_t limit;
	} hue_step_t;

	localparam op_t OP_TICK       = 3'd0;
	localparam op_t OP_TOGGLE     = 3'd1;
	localparam op_t OP_SET_POWER  = 3'd2;
	localparam op_t OP_NIGHT      = 3'd3;
	localparam op_t OP_NEXT_RUN   = 3'd4;
	localparam op_t OP_NEXT_COLOUR = 3'd5;
	localparam op_t OP_HUE_RESET  = 3'd6;

	localparam mode_t MODE_HUE   = 4'd0;
	localparam mode_t MODE_R     = 4'd1;
	localparam mode_t MODE_G     = 4'd2;
	localparam mode_t MODE_B     = 4'd3;
	localparam mode_t MODE_LG    = 4'd4;
	localparam mode_t MODE_LB    = 4'd5;
	localparam mode_t MODE_P     = 4'd6;
	localparam mode_t MODE_Y     = 4'd7;
	localparam mode_t MODE_W     = 4'd8;
	localparam mode_t MODE_NIGHT = 4'd9;
	localparam mode_t MODE_COUNT = 4'd10;

	localparam hue_t HUE_SECTOR1 = 14'd4800;
	localparam hue_t HUE_SECTOR2 = 14'd9600;
	localparam hue_t HUE_LAST    = 14'd14399;
	localparam rem_t REM_SECTOR  = 13'd4800;

	localparam tick_t LIMIT_FAST = 3'd0;
	localparam tick_t LIMIT_MID  = 3'd2;
	localparam tick_t LIMIT_SLOW = 3'd4;

	localparam duty_t HELD_SEED_RED = 11'd72;

endpackage

### rtl/core/rgbhc_hue.sv
// ----------------------------------------------------------------------------
// rgbhc_hue
// Three-sector hue to rgb conversion, hue advance and step band limit.
// ----------------------------------------------------------------------------
module rgbhc_hue #(
	parameter int unsigned PWM_PERIOD = 1000
) (
	input  rgbhc_pkg::hue_t      hue,
	input  rgbhc_pkg::duty_t     frac,
	input  rgbhc_pkg::rem_t      rem,
	output rgbhc_pkg::hue_step_t step
);

	localparam rgbhc_pkg::duty_t PERIOD_D = rgbhc_pkg::duty_t'(PWM_PERIOD);
	localparam rgbhc_pkg::rem_t  PERIOD_R = rgbhc_pkg::rem_t'(PWM_PERIOD);

	rgbhc_pkg::duty_t comp;
	rgbhc_pkg::rem_t  rem_sum;
	logic             sector_end;

	always_comb begin
		comp       = PERIOD_D - frac;
		rem_sum    = rem + PERIOD_R;
		sector_end = (hue == rgbhc_pkg::HUE_SECTOR1 - 14'd1) ||
			(hue == rgbhc_pkg::HUE_SECTOR2 - 14'd1) || (hue == rgbhc_pkg::HUE_LAST);

		if (hue >= rgbhc_pkg::HUE_SECTOR2) begin
			step.red   = frac;
			step.green = '0;
			step.blue  = comp;
		end else if (hue >= rgbhc_pkg::HUE_SECTOR1) begin
			step.red   = '0;
			step.green = comp;
			step.blue  = frac;
		end else begin
			step.red   = comp;
			step.green = frac;
			step.blue  = '0;
		end

		step.hue_nxt = (hue == rgbhc_pkg::HUE_LAST) ? '0 : hue + 14'd1;

		if (sector_end) begin
			step.frac_nxt = '0;
			step.rem_nxt  = '0;
		end else if (rem_sum >= rgbhc_pkg::REM_SECTOR) begin
			step.frac_nxt = frac + 11'd1;
			step.rem_nxt  = rem_sum - rgbhc_pkg::REM_SECTOR;
		end else begin
			step.frac_nxt = frac;
			step.rem_nxt  = rem_sum;
		end

		priority if ((hue > 14'd1600 && hue < 14'd3200) || (hue > 14'd6400 && hue < 14'd8000) ||
			(hue > 14'd11200 && hue < 14'd12800)) begin
			step.limit = rgbhc_pkg::LIMIT_FAST;
		end else if (hue > 14'd13600 || hue < 14'd800 || (hue > 14'd4000 && hue < 14'd5600) ||
			(hue > 14'd8800 && hue < 14'd10400)) begin
			step.limit = rgbhc_pkg::LIMIT_SLOW;
		end else begin
			step.limit = rgbhc_pkg::LIMIT_MID;
		end
	end

endmodule

### rtl/core/rgbhc_obuf.sv
// ----------------------------------------------------------------------------
// rgbhc_obuf
// Result register with a skid entry so a transaction can enter during a stall.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rgbhc_obuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  rgbhc_pkg::res_t   in_data,
	output logic              res_valid,
	input  logic              res_ready,
	output rgbhc_pkg::res_t   res
);

	logic            skid_v_q;
	rgbhc_pkg::res_t skid_q;
	logic            accept;
	logic            drain;

	assign in_ready = !skid_v_q;
	assign accept   = in_valid && in_ready;
	assign drain    = !res_valid || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
			skid_v_q  <= 1'b0;
		end else if (drain) begin
			if (skid_v_q) begin
				res_valid <= 1'b1;
				skid_v_q  <= 1'b0;
			end else begin
				res_valid <= accept;
			end
		end else if (accept) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (drain) begin
			if (skid_v_q) begin
				res <= skid_q;
			end else if (accept) begin
				res <= in_data;
			end
		end else if (accept) begin
			skid_q <= in_data;
		end
	end

	`ASSERT_NEVER(a_skid_without_res, skid_v_q && !res_valid, "skid entry held with empty output")
	`ASSERT_CLK(a_stall_fills_skid, (res_valid && !res_ready && accept) |=> skid_v_q, "stalled transaction lost")
	`ASSERT_CLK(a_skid_order, (res_valid && res_ready && skid_v_q) |=> (res_valid && res == $past(skid_q)), "skid entry out of order")

endmodule

### rtl/core/rgbhc_ctrl.sv
// ----------------------------------------------------------------------------
// rgbhc_ctrl
// Lamp state, mode sequencing, hue stepping and duty selection.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rgbhc_ctrl #(
	parameter int unsigned PWM_PERIOD = 1000
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_wdata,
	input  logic             accept,
	input  rgbhc_pkg::evt_t  evt,
	output rgbhc_pkg::res_t  res_next
);

	localparam rgbhc_pkg::duty_t PERIOD_D = rgbhc_pkg::duty_t'(PWM_PERIOD);
	localparam rgbhc_pkg::duty_t D120 = rgbhc_pkg::duty_t'(PWM_PERIOD * 120 / 100);
	localparam rgbhc_pkg::duty_t D90  = rgbhc_pkg::duty_t'(PWM_PERIOD * 90 / 100);
	localparam rgbhc_pkg::duty_t D60  = rgbhc_pkg::duty_t'(PWM_PERIOD * 60 / 100);
	localparam rgbhc_pkg::duty_t D42  = rgbhc_pkg::duty_t'(PWM_PERIOD * 42 / 100);
	localparam rgbhc_pkg::duty_t D30  = rgbhc_pkg::duty_t'(PWM_PERIOD * 30 / 100);
	localparam rgbhc_pkg::duty_t D12  = rgbhc_pkg::duty_t'(PWM_PERIOD * 12 / 100);

	logic                 remember_q;
	logic                 power_q, power_n;
	rgbhc_pkg::mode_t     mode_q, mode_n;
	rgbhc_pkg::mode_t     saved_q, saved_n;
	rgbhc_pkg::hue_t      hue_q, hue_n;
	rgbhc_pkg::tick_t     ticks_q, ticks_n;
	rgbhc_pkg::duty_t     frac_q, frac_n;
	rgbhc_pkg::rem_t      rem_q, rem_n;
	rgbhc_pkg::duty_t     held_q [3];
	rgbhc_pkg::duty_t     held_n [3];
	rgbhc_pkg::mode_t     mode_tmp;
	rgbhc_pkg::tick_t     ticks_inc;
	rgbhc_pkg::hue_step_t step;

	rgbhc_hue #(
		.PWM_PERIOD(PWM_PERIOD)
	) u_hue (
		.hue (hue_q),
		.frac(frac_q),
		.rem (rem_q),
		.step(step)
	);

	always_comb begin
		power_n   = power_q;
		mode_n    = mode_q;
		saved_n   = saved_q;
		hue_n     = hue_q;
		ticks_n   = ticks_q;
		frac_n    = frac_q;
		rem_n     = rem_q;
		held_n    = held_q;
		ticks_inc = ticks_q + 3'd1;
		mode_tmp  = (mode_q == rgbhc_pkg::MODE_NIGHT) ? saved_q : mode_q + 4'd1;

		unique case (evt.opcode)
			rgbhc_pkg::OP_TICK: begin
				if (power_q && mode_q == rgbhc_pkg::MODE_HUE) begin
					if (ticks_inc > step.limit) begin
						ticks_n   = '0;
						held_n[0] = step.red;
						held_n[1] = step.green;
						held_n[2] = step.blue;
						hue_n     = step.hue_nxt;
						frac_n    = step.frac_nxt;
						rem_n     = step.rem_nxt;
					end else begin
						ticks_n = ticks_inc;
					end
				end
			end
			rgbhc_pkg::OP_TOGGLE: begin
				power_n = !power_q;
				if (!power_q) begin
					mode_n = saved_q;
				end
			end
			rgbhc_pkg::OP_SET_POWER: begin
				power_n = evt.power_value;
				if (mode_q != rgbhc_pkg::MODE_NIGHT) begin
					if (evt.power_value) begin
						mode_n = saved_q;
					end else begin
						saved_n = mode_q;
					end
				end
			end
			rgbhc_pkg::OP_NIGHT: begin
				saved_n = mode_q;
				mode_n  = rgbhc_pkg::MODE_NIGHT;
			end
			rgbhc_pkg::OP_NEXT_RUN: begin
				if (mode_tmp >= rgbhc_pkg::MODE_COUNT) begin
					mode_n    = rgbhc_pkg::MODE_HUE;
					hue_n     = '0;
					ticks_n   = '0;
					frac_n    = '0;
					rem_n     = '0;
					held_n[0] = rgbhc_pkg::HELD_SEED_RED;
					held_n[1] = '0;
					held_n[2] = '0;
				end else begin
					mode_n = mode_tmp;
				end
				if (remember_q && mode_n != rgbhc_pkg::MODE_NIGHT) begin
					saved_n = mode_n;
				end
			end
			rgbhc_pkg::OP_NEXT_COLOUR: begin
				if (mode_q + 4'd1 >= rgbhc_pkg::MODE_COUNT || mode_q + 4'd1 < rgbhc_pkg::MODE_R) begin
					mode_n = rgbhc_pkg::MODE_R;
				end else begin
					mode_n = mode_q + 4'd1;
				end
			end
			rgbhc_pkg::OP_HUE_RESET: begin
				mode_n    = rgbhc_pkg::MODE_HUE;
				hue_n     = '0;
				ticks_n   = '0;
				frac_n    = '0;
				rem_n     = '0;
				held_n[0] = PERIOD_D;
				held_n[1] = '0;
				held_n[2] = '0;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res_next.red_duty    = '0;
		res_next.green_duty  = '0;
		res_next.blue_duty   = '0;
		res_next.lamp_on     = power_n;
		res_next.active_mode = mode_n;
		if (power_n) begin
			unique case (mode_n)
				rgbhc_pkg::MODE_HUE: begin
					res_next.red_duty   = held_n[0];
					res_next.green_duty = held_n[1];
					res_next.blue_duty  = held_n[2];
				end
				rgbhc_pkg::MODE_R: res_next.red_duty = D120;
				rgbhc_pkg::MODE_G: res_next.green_duty = D120;
				rgbhc_pkg::MODE_B: res_next.blue_duty = D120;
				rgbhc_pkg::MODE_LG: begin
					res_next.green_duty = D90;
					res_next.blue_duty  = D30;
				end
				rgbhc_pkg::MODE_LB: begin
					res_next.green_duty = D30;
					res_next.blue_duty  = D90;
				end
				rgbhc_pkg::MODE_P: begin
					res_next.red_duty  = D60;
					res_next.blue_duty = D60;
				end
				rgbhc_pkg::MODE_Y: begin
					res_next.red_duty   = D60;
					res_next.green_duty = D60;
				end
				rgbhc_pkg::MODE_W: begin
					res_next.red_duty   = D42;
					res_next.green_duty = D42;
					res_next.blue_duty  = D42;
				end
				rgbhc_pkg::MODE_NIGHT: begin
					res_next.red_duty   = D90;
					res_next.green_duty = D12;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remember_q <= 1'b0;
			power_q    <= 1'b0;
			mode_q     <= rgbhc_pkg::MODE_HUE;
			saved_q    <= rgbhc_pkg::MODE_HUE;
			hue_q      <= '0;
			ticks_q    <= '0;
			frac_q     <= '0;
			rem_q      <= '0;
			held_q[0]  <= '0;
			held_q[1]  <= '0;
			held_q[2]  <= '0;
		end else begin
			if (cfg_we) begin
				remember_q <= cfg_wdata;
			end
			if (accept) begin
				power_q <= power_n;
				mode_q  <= mode_n;
				saved_q <= saved_n;
				hue_q   <= hue_n;
				ticks_q <= ticks_n;
				frac_q  <= frac_n;
				rem_q   <= rem_n;
				held_q  <= held_n;
			end
		end
	end

	`ASSERT_CLK(a_hue_reset, (accept && evt.opcode == rgbhc_pkg::OP_HUE_RESET) |=> (hue_q == '0 && ticks_q == '0 && frac_q == '0), "hue reset not applied")
	`ASSERT_CLK(a_off_tick_holds, (accept && evt.opcode == rgbhc_pkg::OP_TICK && !power_q) |=> ($stable(hue_q) && $stable(ticks_q)), "hue moved while off")

endmodule

### rtl/core/rgb_led_hue_cycle_mode_controller.sv
// an accepted result is registered in res, or in the skid entry if res stalls
// throughput: one transaction per cycle, sustained while res is taken each cycle
// a two-entry result buffer takes one more transaction while res is stalled
// reset: arst_n clears power, modes, hue, tick count and held duties at once
// ----------------------------------------------------------------------------
// rgb_led_hue_cycle_mode_controller
// Rgb lamp mode controller with a hue-cycle mode giving three pwm duties.
// ----------------------------------------------------------------------------
module rgb_led_hue_cycle_mode_controller #(
	parameter int unsigned PWM_PERIOD = 1000
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_wdata,
	input  logic             evt_valid,
	output logic             evt_ready,
	input  rgbhc_pkg::evt_t  evt,
	output logic             res_valid,
	input  logic             res_ready,
	output rgbhc_pkg::res_t  res
);

	rgbhc_pkg::res_t res_next;
	logic            accept;

	assign accept = evt_valid && evt_ready;

	rgbhc_ctrl #(
		.PWM_PERIOD(PWM_PERIOD)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.accept   (accept),
		.evt      (evt),
		.res_next (res_next)
	);

	rgbhc_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (evt_valid),
		.in_ready (evt_ready),
		.in_data  (res_next),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rgb lamp hue-cycle mode controller. Event
// transactions go in over a valid/ready channel. A built-in model of the lamp
// predicts every result transaction, and each result is checked field by field.
// The run covers directed mode and power cases, a long run of hue steps,
// and weighted random traffic with the step-memory register in both
// settings. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int unsigned       PERIOD        = 1000;
	localparam int unsigned       QUIET_LIMIT   = 1000;
	localparam int unsigned       SETTLE_CYCLES = 4;
	localparam int unsigned       HUE_WALK      = 300;
	localparam int unsigned       RANDOM_COUNT  = 640;
	localparam rgbhc_pkg::op_t    OP_SPARE      = 3'd7;

	logic            clk       = 1'b0;
	logic            arst_n    = 1'b0;
	logic            cfg_we    = 1'b0;
	logic            cfg_wdata = 1'b0;
	logic            evt_valid = 1'b0;
	logic            evt_ready;
	rgbhc_pkg::evt_t evt       = '0;
	logic            res_valid;
	logic            res_ready = 1'b0;
	rgbhc_pkg::res_t res;

	// lamp model state
	bit               remember_on_step = 1'b0;
	logic             lamp_power       = 1'b0;
	rgbhc_pkg::mode_t mode_cur         = rgbhc_pkg::MODE_HUE;
	rgbhc_pkg::mode_t mode_mem         = rgbhc_pkg::MODE_HUE;
	rgbhc_pkg::hue_t  hue_pos          = '0;
	rgbhc_pkg::tick_t tick_count       = '0;
	rgbhc_pkg::duty_t hold_duty [3]    = '{default: '0};

	rgbhc_pkg::res_t lamp_expect_q [$];
	rgbhc_pkg::res_t want_res;
	int unsigned     fail_count   = 0;
	int unsigned     quiet_cycles = 0;
	int unsigned     hold_left    = 0;
	int unsigned     rx_stall;
	bit              jitter_on    = 1'b1;

	always #2 clk = ~clk;

	rgb_led_hue_cycle_mode_controller #(
		.PWM_PERIOD(PERIOD)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.evt_valid(evt_valid),
		.evt_ready(evt_ready),
		.evt(evt),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	// mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (!jitter_on || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic rgbhc_pkg::duty_t pct_of(int unsigned p);
		return rgbhc_pkg::duty_t'(PERIOD * p / 100);
	endfunction

	function automatic rgbhc_pkg::res_t lamp_outputs();
		rgbhc_pkg::res_t r;
		r = '0;
		r.lamp_on = lamp_power;
		r.active_mode = mode_cur;
		if (lamp_power) begin
			case (mode_cur)
				rgbhc_pkg::MODE_HUE: begin
					r.red_duty = hold_duty[0];
					r.green_duty = hold_duty[1];
					r.blue_duty = hold_duty[2];
				end
				rgbhc_pkg::MODE_R: r.red_duty = pct_of(120);
				rgbhc_pkg::MODE_G: r.green_duty = pct_of(120);
				rgbhc_pkg::MODE_B: r.blue_duty = pct_of(120);
				rgbhc_pkg::MODE_LG: begin
					r.green_duty = pct_of(90);
					r.blue_duty = pct_of(30);
				end
				rgbhc_pkg::MODE_LB: begin
					r.green_duty = pct_of(30);
					r.blue_duty = pct_of(90);
				end
				rgbhc_pkg::MODE_P: begin
					r.red_duty = pct_of(60);
					r.blue_duty = pct_of(60);
				end
				rgbhc_pkg::MODE_Y: begin
					r.red_duty = pct_of(60);
					r.green_duty = pct_of(60);
				end
				rgbhc_pkg::MODE_W: begin
					r.red_duty = pct_of(42);
					r.green_duty = pct_of(42);
					r.blue_duty = pct_of(42);
				end
				rgbhc_pkg::MODE_NIGHT: begin
					r.red_duty = pct_of(90);
					r.green_duty = pct_of(12);
				end
				default: ;
			endcase
		end
		return r;
	endfunction

	function automatic void apply_lamp_event(rgbhc_pkg::evt_t e);
		rgbhc_pkg::tick_t lim;
		int unsigned      sector, frac, part_a, part_b;
		case (e.opcode)
			rgbhc_pkg::OP_TICK: begin
				if (lamp_power && mode_cur == rgbhc_pkg::MODE_HUE) begin
					tick_count = tick_count + 1'b1;
					if ((hue_pos > 1600 && hue_pos < 3200) ||
					    (hue_pos > 6400 && hue_pos < 8000) ||
					    (hue_pos > 11200 && hue_pos < 12800))
						lim = rgbhc_pkg::LIMIT_FAST;
					else if (hue_pos > 13600 || hue_pos < 800 ||
					         (hue_pos > 4000 && hue_pos < 5600) ||
					         (hue_pos > 8800 && hue_pos < 10400))
						lim = rgbhc_pkg::LIMIT_SLOW;
					else
						lim = rgbhc_pkg::LIMIT_MID;
					if (tick_count > lim) begin
						tick_count = '0;
						sector = hue_pos / rgbhc_pkg::HUE_SECTOR1;
						frac = hue_pos % rgbhc_pkg::HUE_SECTOR1;
						part_a = PERIOD * frac / rgbhc_pkg::HUE_SECTOR1;
						part_b = PERIOD - part_a;
						case (sector)
							0: hold_duty = '{rgbhc_pkg::duty_t'(part_b),
								rgbhc_pkg::duty_t'(part_a), '0};
							1: hold_duty = '{'0, rgbhc_pkg::duty_t'(part_b),
								rgbhc_pkg::duty_t'(part_a)};
							default: hold_duty = '{rgbhc_pkg::duty_t'(part_a), '0,
								rgbhc_pkg::duty_t'(part_b)};
						endcase
						hue_pos = (hue_pos >= rgbhc_pkg::HUE_LAST) ? '0 : hue_pos + 1'b1;
					end
				end
			end
			rgbhc_pkg::OP_TOGGLE: begin
				lamp_power = ~lamp_power;
				if (lamp_power)
					mode_cur = mode_mem;
			end
			rgbhc_pkg::OP_SET_POWER: begin
				lamp_power = e.power_value;
				if (mode_cur != rgbhc_pkg::MODE_NIGHT) begin
					if (lamp_power)
						mode_cur = mode_mem;
					else
						mode_mem = mode_cur;
				end
			end
			rgbhc_pkg::OP_NIGHT: begin
				mode_mem = mode_cur;
				mode_cur = rgbhc_pkg::MODE_NIGHT;
			end
			rgbhc_pkg::OP_NEXT_RUN: begin
				if (mode_cur == rgbhc_pkg::MODE_NIGHT)
					mode_cur = mode_mem;
				else
					mode_cur = mode_cur + 1'b1;
				if (mode_cur >= rgbhc_pkg::MODE_COUNT) begin
					mode_cur = rgbhc_pkg::MODE_HUE;
					hue_pos = '0;
					tick_count = '0;
					hold_duty = '{rgbhc_pkg::HELD_SEED_RED, '0, '0};
				end
				if (remember_on_step && mode_cur != rgbhc_pkg::MODE_NIGHT)
					mode_mem = mode_cur;
			end
			rgbhc_pkg::OP_NEXT_COLOUR: begin
				mode_cur = mode_cur + 1'b1;
				if (mode_cur >= rgbhc_pkg::MODE_COUNT || mode_cur < rgbhc_pkg::MODE_R)
					mode_cur = rgbhc_pkg::MODE_R;
			end
			rgbhc_pkg::OP_HUE_RESET: begin
				mode_cur = rgbhc_pkg::MODE_HUE;
				hue_pos = '0;
				tick_count = '0;
				hold_duty = '{rgbhc_pkg::duty_t'(PERIOD), '0, '0};
			end
			default: ;
		endcase
		lamp_expect_q.push_back(lamp_outputs());
	endfunction

	// called at a rising edge; returns at the edge where the transaction is taken
	task automatic send_event(input rgbhc_pkg::op_t op, input logic pv);
		int unsigned     gap;
		rgbhc_pkg::evt_t e;
		e.opcode = op;
		e.power_value = pv;
		gap = pick_gap();
		if (gap != 0) begin
			evt_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt <= e;
		evt_valid <= 1'b1;
		do @(posedge clk); while (!evt_ready);
		apply_lamp_event(e);
	endtask

	task automatic wait_for_results();
		evt_valid <= 1'b0;
		while (lamp_expect_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_step_memory(input bit v);
		wait_for_results();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		remember_on_step = v;
	endtask

	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			fail_count++;
			$error("%s: expected %0d, got %0d", name, want, got);
		end
	endtask

	task automatic test_directed_events();
		send_event(rgbhc_pkg::OP_TICK, 1'b1);
		send_event(OP_SPARE, 1'b1);
		send_event(rgbhc_pkg::OP_SET_POWER, 1'b1);
		repeat (5) send_event(rgbhc_pkg::OP_TICK, 1'b0);
		send_event(rgbhc_pkg::OP_NEXT_COLOUR, 1'b0);
		send_event(rgbhc_pkg::OP_TICK, 1'b1);
		// walk the colours up to night and round to red
		repeat (9) send_event(rgbhc_pkg::OP_NEXT_COLOUR, 1'b1);
		send_event(rgbhc_pkg::OP_SET_POWER, 1'b0);
		send_event(rgbhc_pkg::OP_SET_POWER, 1'b1);
		send_event(rgbhc_pkg::OP_NIGHT, 1'b0);
		send_event(rgbhc_pkg::OP_NIGHT, 1'b1);
		send_event(rgbhc_pkg::OP_NEXT_RUN, 1'b0);
		send_event(rgbhc_pkg::OP_SET_POWER, 1'b0);
		send_event(rgbhc_pkg::OP_SET_POWER, 1'b1);
		send_event(rgbhc_pkg::OP_TOGGLE, 1'b1);
		send_event(rgbhc_pkg::OP_TOGGLE, 1'b0);
		send_event(rgbhc_pkg::OP_HUE_RESET, 1'b0);
		write_step_memory(1'b1);
		repeat (3) send_event(rgbhc_pkg::OP_NEXT_RUN, 1'b1);
		send_event(rgbhc_pkg::OP_TOGGLE, 1'b0);
		send_event(rgbhc_pkg::OP_TOGGLE, 1'b1);
	endtask

	task automatic test_hue_walk();
		send_event(rgbhc_pkg::OP_SET_POWER, 1'b1);
		send_event(rgbhc_pkg::OP_HUE_RESET, 1'b1);
		for (int unsigned n = 0; n < HUE_WALK; n++) begin
			jitter_on = (n % 100) < 30;
			send_event(rgbhc_pkg::OP_TICK, n[0]);
		end
		jitter_on = 1'b1;
	endtask

	task automatic test_random_traffic(input int unsigned count);
		int unsigned    r;
		rgbhc_pkg::op_t op;
		for (int unsigned i = 0; i < count; i++) begin
			if (i % 150 == 0)
				jitter_on = $urandom_range(0, 3) != 0;
			if (i == count / 2 || $urandom_range(0, 99) == 0)
				wait_for_results();
			r = $urandom_range(0, 99);
			if (r < 55)
				op = rgbhc_pkg::OP_TICK;
			else if (r < 60)
				op = rgbhc_pkg::OP_TOGGLE;
			else if (r < 67)
				op = rgbhc_pkg::OP_SET_POWER;
			else if (r < 71)
				op = rgbhc_pkg::OP_NIGHT;
			else if (r < 79)
				op = rgbhc_pkg::OP_NEXT_RUN;
			else if (r < 87)
				op = rgbhc_pkg::OP_NEXT_COLOUR;
			else if (r < 95)
				op = rgbhc_pkg::OP_HUE_RESET;
			else
				op = OP_SPARE;
			send_event(op, 1'($urandom_range(0, 1)));
		end
		jitter_on = 1'b1;
	endtask

	// result side stalls
	always @(posedge clk) begin
		if (!jitter_on) begin
			res_ready <= 1'b1;
		end else if (hold_left != 0) begin
			res_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			rx_stall = pick_gap();
			if (rx_stall == 0) begin
				res_ready <= 1'b1;
			end else begin
				res_ready <= 1'b0;
				hold_left <= rx_stall - 1;
			end
		end
	end

	// result checking
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (lamp_expect_q.size() == 0) begin
				fail_count++;
				$error("result transaction with no expectation pending");
			end else begin
				want_res = lamp_expect_q.pop_front();
				check_field("red_duty", want_res.red_duty, res.red_duty);
				check_field("green_duty", want_res.green_duty, res.green_duty);
				check_field("blue_duty", want_res.blue_duty, res.blue_duty);
				check_field("lamp_on", want_res.lamp_on, res.lamp_on);
				check_field("active_mode", want_res.active_mode, res.active_mode);
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if ((evt_valid && evt_ready) || (res_valid && res_ready)) begin
			quiet_cycles <= 0;
		end else if (arst_n) begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_step_memory(1'b0);
		test_directed_events();
		test_hue_walk();
		write_step_memory(1'b1);
		test_random_traffic(RANDOM_COUNT);
		write_step_memory(1'b0);
		test_random_traffic(RANDOM_COUNT);
		wait_for_results();
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
